FILE: rtl/json_string_unescape_utf8_assert.svh
// assertion macros used by the unescaper's result buffer
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// same-cycle implication, checked out of reset
`define JSU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// next-cycle implication, checked out of reset
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`endif

FILE: rtl/jsu_pkg.sv
// types and constants for the json string unescaper
package jsu_pkg;

    localparam logic [2:0] MODE_NORMAL  = 3'd0;
    localparam logic [2:0] MODE_ESC     = 3'd1;
    localparam logic [2:0] MODE_HEX1    = 3'd2;
    localparam logic [2:0] MODE_SURR_BS = 3'd3;
    localparam logic [2:0] MODE_SURR_U  = 3'd4;
    localparam logic [2:0] MODE_HEX2    = 3'd5;

    localparam logic [7:0] CHR_BSLASH = 8'h5C;
    localparam logic [7:0] CHR_QUOTE  = 8'h22;
    localparam logic [7:0] CHR_SLASH  = 8'h2F;
    localparam logic [7:0] CHR_N      = 8'h6E;
    localparam logic [7:0] CHR_T      = 8'h74;
    localparam logic [7:0] CHR_R      = 8'h72;
    localparam logic [7:0] CHR_B      = 8'h62;
    localparam logic [7:0] CHR_F      = 8'h66;
    localparam logic [7:0] CHR_U      = 8'h75;
    localparam logic [7:0] CHR_UPPER_A = 8'h41;

    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [11:0] acc;
        logic [1:0]  cnt;
        logic [9:0]  hs;
    } jsu_state_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            has_data;
        logic            str_end;
    } jsu_burst_t;

endpackage

FILE: rtl/jsu_decode.sv
// escape decoder and utf-8 encoder for one registered input item
module jsu_decode
    import jsu_pkg::*;
(
    input  jsu_state_t state,
    input  logic [7:0] in_byte,
    input  logic       string_end,
    output jsu_state_t state_next,
    output jsu_burst_t burst
);

    function automatic jsu_burst_t encode_utf8(input logic [20:0] cp);
        jsu_burst_t r;
        r = '0;
        if (cp < 21'h80) begin
            r.bytes[0] = cp[7:0];
            r.last_idx = 2'd0;
        end
        else if (cp < 21'h800) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.last_idx = 2'd1;
        end
        else if (cp < SUPP_BASE) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.last_idx = 2'd2;
        end
        else begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.last_idx = 2'd3;
        end
        return r;
    endfunction

    logic [7:0]  folded;
    logic [3:0]  nib;
    logic [15:0] hex_val;

    always_comb
    begin
        folded = (in_byte >= CHR_UPPER_A) ? ((in_byte & 8'hDF) - 8'd7) : in_byte;
        nib = folded[3:0];
        hex_val = {state.acc, nib};
    end

    logic        do_plain;
    logic        do_esc;
    logic        emit_one;
    logic [7:0]  one_byte;
    logic        emit_cp;
    logic [20:0] cp;

    always_comb
    begin
        state_next = state;
        do_plain = 1'b0;
        do_esc = 1'b0;
        emit_one = 1'b0;
        one_byte = '0;
        emit_cp = 1'b0;
        cp = '0;

        case (state.mode)
            MODE_ESC: do_esc = 1'b1;
            MODE_HEX1, MODE_HEX2:
            begin
                state_next.acc = hex_val[11:0];
                if (state.cnt != 2'd3) begin
                    state_next.cnt = state.cnt + 2'd1;
                end
                else begin
                    state_next.cnt = 2'd0;
                    if (state.mode == MODE_HEX2) begin
                        cp = SUPP_BASE + {1'b0, state.hs, hex_val[9:0]};
                        emit_cp = 1'b1;
                        state_next.mode = MODE_NORMAL;
                        state_next.hs = '0;
                    end
                    else if (hex_val[15:10] == HIGH_SURR_TAG) begin
                        state_next.hs = hex_val[9:0];
                        state_next.mode = MODE_SURR_BS;
                    end
                    else begin
                        cp = {5'd0, hex_val};
                        emit_cp = 1'b1;
                        state_next.mode = MODE_NORMAL;
                    end
                end
            end
            MODE_SURR_BS:
            begin
                if (in_byte == CHR_BSLASH) begin
                    state_next.mode = MODE_SURR_U;
                end
                else begin
                    state_next.hs = '0;
                    do_plain = 1'b1;
                end
            end
            MODE_SURR_U:
            begin
                if (in_byte == CHR_U) begin
                    state_next.mode = MODE_HEX2;
                    state_next.acc = '0;
                    state_next.cnt = 2'd0;
                end
                else begin
                    state_next.hs = '0;
                    do_esc = 1'b1;
                end
            end
            default: do_plain = 1'b1;
        endcase

        if (do_plain) begin
            if (in_byte == CHR_BSLASH) begin
                state_next.mode = MODE_ESC;
            end
            else begin
                state_next.mode = MODE_NORMAL;
                emit_one = 1'b1;
                one_byte = in_byte;
            end
        end

        if (do_esc) begin
            state_next.mode = MODE_NORMAL;
            emit_one = 1'b1;
            case (in_byte)
                CHR_N:      one_byte = 8'h0A;
                CHR_T:      one_byte = 8'h09;
                CHR_R:      one_byte = 8'h0D;
                CHR_B:      one_byte = 8'h08;
                CHR_F:      one_byte = 8'h0C;
                CHR_BSLASH: one_byte = 8'h5C;
                CHR_QUOTE:  one_byte = 8'h22;
                CHR_SLASH:  one_byte = 8'h2F;
                CHR_U:
                begin
                    emit_one = 1'b0;
                    state_next.mode = MODE_HEX1;
                    state_next.acc = '0;
                    state_next.cnt = 2'd0;
                end
                default: emit_one = 1'b0;
            endcase
        end

        if (emit_cp) begin
            burst = encode_utf8(cp);
        end
        else begin
            burst = '0;
            burst.bytes[0] = one_byte;
            burst.last_idx = 2'd0;
        end
        burst.has_data = emit_cp | emit_one;
        burst.str_end = string_end;

        if (string_end) begin
            state_next = '0;
        end
    end

endmodule

FILE: rtl/jsu_out.sv
// result buffer that hands out a burst of up to four bytes, one item per cycle while out_ready is high
module jsu_out
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load_valid,
    input  jsu_burst_t load,
    output logic       load_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last_of_run,
    output logic       string_done
);

    `include "json_string_unescape_utf8_assert.svh"

    logic       full_reg;
    logic       full_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    jsu_burst_t burst_reg;
    logic       is_last;

    assign is_last = (idx_reg == burst_reg.last_idx);
    assign load_ready = !full_reg || (out_ready && is_last);

    always_comb
    begin
        full_next = full_reg;
        idx_next = idx_reg;
        if (load_valid && load_ready) begin
            full_next = 1'b1;
            idx_next = 2'd0;
        end
        else if (full_reg && out_ready) begin
            if (is_last) begin
                full_next = 1'b0;
            end
            else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            full_reg <= 1'b0;
            idx_reg <= 2'd0;
        end
        else begin
            full_reg <= full_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready) begin
            burst_reg <= load;
        end
    end

    assign out_valid = full_reg;
    assign out_byte = burst_reg.bytes[idx_reg];
    assign byte_valid = burst_reg.has_data;
    assign last_of_run = is_last;
    assign string_done = is_last && burst_reg.str_end;

    // loads only into a free or draining buffer
    `JSU_ASSERT_IMPL(a_load_ok, clk, rst_n, load_valid, load_ready)
    // an empty end marker is a single result
    `JSU_ASSERT_IMPL(a_marker_single, clk, rst_n, full_reg && !burst_reg.has_data,
        last_of_run && string_done)
    // a partly sent burst stays in the buffer
    `JSU_ASSERT_NEXT(a_burst_holds, clk, rst_n, full_reg && out_ready && !is_last,
        full_reg && idx_reg != 2'd0)

endmodule

FILE: rtl/json_string_unescape_utf8.sv
// json string body unescaper with utf-8 output, top level
//
//  channel | handshake            | payload
//  input   | in_valid / in_ready  | in_byte, string_end
//  output  | out_valid / out_ready| out_byte, byte_valid, last_of_run, string_done
//
// an accepted item is held in the input register, then decodes into the result buffer
// one item per cycle while out_ready is high and each gives at most one result; after a
// utf-8 burst, the next item with a result waits in the input register until the burst ends
// items with no result (escape prefixes, hex digits) pass through without using the buffer
// reset clears the escape state and both valid flags
// a stalled output backs up into in_ready through the input register
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       string_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last_of_run,
    output logic       string_done
);

    logic       in_full_reg;
    logic       in_full_next;
    logic [7:0] byte_reg;
    logic       end_reg;
    jsu_state_t state_reg;
    jsu_state_t state_next;
    jsu_burst_t burst;
    logic       emits;
    logic       load_ready;
    logic       advance;

    jsu_decode u_decode (
        .state      (state_reg),
        .in_byte    (byte_reg),
        .string_end (end_reg),
        .state_next (state_next),
        .burst      (burst)
    );

    assign emits = burst.has_data || burst.str_end;
    assign advance = in_full_reg && (!emits || load_ready);
    assign in_ready = !in_full_reg || advance;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_valid && in_ready) begin
            in_full_next = 1'b1;
        end
        else if (advance) begin
            in_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_full_reg <= 1'b0;
            state_reg <= '0;
        end
        else begin
            in_full_reg <= in_full_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            byte_reg <= in_byte;
            end_reg <= string_end;
        end
    end

    jsu_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (advance && emits),
        .load        (burst),
        .load_ready  (load_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .last_of_run (last_of_run),
        .string_done (string_done)
    );

endmodule

FILE: tb/json_string_unescape_utf8_checker.sv
`timescale 1ns / 1ps
// scoreboard for the json string unescaper: predicts decoded utf-8 bytes and checks the output
module json_string_unescape_utf8_checker
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       string_end,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       byte_valid,
    input  logic       last_of_run,
    input  logic       string_done,
    output int         mismatch_count,
    output int         outstanding
);

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       run_last;
        logic       str_last;
    } decoded_t;

    decoded_t   decoded_q[$];
    decoded_t   want;
    logic [7:0] burst[$];

    logic [2:0]  esc_mode;
    logic [15:0] hex_acc;
    logic [1:0]  digit_cnt;
    logic [15:0] high_half;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = c;
        if (v >= CHR_UPPER_A)
        begin
            v = (v & 8'hDF) - 8'd7;
        end
        v = v - "0";
        return v[3:0];
    endfunction

    function void put_utf8(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            burst.push_back(cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            burst.push_back({3'b110, cp[10:6]});
            burst.push_back({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            burst.push_back({4'b1110, cp[15:12]});
            burst.push_back({2'b10, cp[11:6]});
            burst.push_back({2'b10, cp[5:0]});
        end
        else
        begin
            burst.push_back({5'b11110, cp[20:18]});
            burst.push_back({2'b10, cp[17:12]});
            burst.push_back({2'b10, cp[11:6]});
            burst.push_back({2'b10, cp[5:0]});
        end
    endfunction

    function void take_plain(input logic [7:0] c);
        esc_mode = MODE_NORMAL;
        if (c == CHR_BSLASH)
        begin
            esc_mode = MODE_ESC;
        end
        else
        begin
            burst.push_back(c);
        end
    endfunction

    function void take_escape(input logic [7:0] c);
        esc_mode = MODE_NORMAL;
        case (c)
            CHR_N:      burst.push_back(8'h0A);
            CHR_T:      burst.push_back(8'h09);
            CHR_R:      burst.push_back(8'h0D);
            CHR_B:      burst.push_back(8'h08);
            CHR_F:      burst.push_back(8'h0C);
            CHR_BSLASH: burst.push_back(CHR_BSLASH);
            CHR_QUOTE:  burst.push_back(CHR_QUOTE);
            CHR_SLASH:  burst.push_back(CHR_SLASH);
            CHR_U:
            begin
                esc_mode  = MODE_HEX1;
                hex_acc   = '0;
                digit_cnt = '0;
            end
            default: ;
        endcase
    endfunction

    task automatic predict_item(input logic [7:0] c, input logic fin);
        int n;
        burst.delete();
        case (esc_mode)
            MODE_ESC: take_escape(c);
            MODE_HEX1, MODE_HEX2:
            begin
                hex_acc = {hex_acc[11:0], hex_value(c)};
                if (digit_cnt != 2'd3)
                begin
                    digit_cnt = digit_cnt + 2'd1;
                end
                else
                begin
                    digit_cnt = '0;
                    if (esc_mode == MODE_HEX2)
                    begin
                        put_utf8(SUPP_BASE + {1'b0, high_half[9:0], hex_acc[9:0]});
                        esc_mode  = MODE_NORMAL;
                        high_half = '0;
                    end
                    else if (hex_acc[15:10] == HIGH_SURR_TAG)
                    begin
                        high_half = hex_acc;
                        esc_mode  = MODE_SURR_BS;
                    end
                    else
                    begin
                        esc_mode = MODE_NORMAL;
                        put_utf8({5'd0, hex_acc});
                    end
                end
            end
            MODE_SURR_BS:
            begin
                if (c == CHR_BSLASH)
                begin
                    esc_mode = MODE_SURR_U;
                end
                else
                begin
                    high_half = '0;
                    take_plain(c);
                end
            end
            MODE_SURR_U:
            begin
                if (c == CHR_U)
                begin
                    esc_mode  = MODE_HEX2;
                    hex_acc   = '0;
                    digit_cnt = '0;
                end
                else
                begin
                    high_half = '0;
                    take_escape(c);
                end
            end
            default: take_plain(c);
        endcase
        if (fin)
        begin
            esc_mode  = MODE_NORMAL;
            hex_acc   = '0;
            digit_cnt = '0;
            high_half = '0;
        end
        n = burst.size();
        if (n == 0)
        begin
            if (fin)
            begin
                decoded_q.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
            end
        end
        else
        begin
            for (int k = 0; k < n; k++)
            begin
                decoded_q.push_back('{burst[k], 1'b1, k == n - 1, (k == n - 1) && fin});
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decoded_q.delete();
            esc_mode       = MODE_NORMAL;
            hex_acc        = '0;
            digit_cnt      = '0;
            high_half      = '0;
            mismatch_count = 0;
            outstanding   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_item(in_byte, string_end);
            end
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected item: out_byte %h", out_byte);
                    mismatch_count++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %h, actual %h", want.data, out_byte);
                        mismatch_count++;
                    end
                    if (byte_valid !== want.has_data)
                    begin
                        $error("byte_valid: expected %b, actual %b", want.has_data, byte_valid);
                        mismatch_count++;
                    end
                    if (last_of_run !== want.run_last)
                    begin
                        $error("last_of_run: expected %b, actual %b", want.run_last,
                               last_of_run);
                        mismatch_count++;
                    end
                    if (string_done !== want.str_last)
                    begin
                        $error("string_done: expected %b, actual %b", want.str_last,
                               string_done);
                        mismatch_count++;
                    end
                end
            end
            outstanding <= decoded_q.size();
        end
    end

endmodule

FILE: tb/json_string_unescape_utf8_tb.sv
`timescale 1ns / 1ps
// testbench top for the json string unescaper: drives escaped strings and gives the verdict
module json_string_unescape_utf8_tb
    import jsu_pkg::*;
();

    localparam int RANDOM_ITEMS = 180;
    localparam logic [7:0] ESC_CHARS [8] = '{CHR_N, CHR_T, CHR_R, CHR_B, CHR_F,
                                             CHR_BSLASH, CHR_QUOTE, CHR_SLASH};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       string_end = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       string_done;

    int         mismatch_count;
    int         outstanding;
    int         items_sent = 0;
    bit         steady = 1'b0;
    logic [7:0] token_bytes[$];

    always #5 clk = ~clk;

    json_string_unescape_utf8 i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .string_end  (string_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .last_of_run (last_of_run),
        .string_done (string_done)
    );

    json_string_unescape_utf8_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .string_end     (string_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .last_of_run    (last_of_run),
        .string_done    (string_done),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_item(input logic [7:0] b, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_byte    <= b;
        string_end <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string s, input logic end_last);
        for (int k = 0; k < s.len(); k++)
        begin
            send_item(s[k], end_last && (k == s.len() - 1));
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    function void push_hex4(input logic [15:0] v);
        logic [3:0] nib;
        logic [7:0] ch;
        for (int k = 3; k >= 0; k--)
        begin
            nib = v[k * 4 +: 4];
            if ($urandom_range(0, 39) == 0)
            begin
                ch = 8'($urandom_range(0, 255));
            end
            else if (nib < 4'd10)
            begin
                ch = "0" + nib;
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                ch = CHR_UPPER_A + nib - 8'd10;
            end
            else
            begin
                ch = "a" + nib - 8'd10;
            end
            token_bytes.push_back(ch);
        end
    endfunction

    function void push_escape_u();
        token_bytes.push_back(CHR_BSLASH);
        token_bytes.push_back(CHR_U);
    endfunction

    task automatic send_token();
        int         r;
        int         last;
        logic [15:0] cp;
        logic        fin;
        token_bytes.delete();
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            token_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 50)
        begin
            token_bytes.push_back(CHR_BSLASH);
            if ($urandom_range(0, 4) == 0)
            begin
                token_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                token_bytes.push_back(ESC_CHARS[$urandom_range(0, 7)]);
            end
        end
        else if (r < 75)
        begin
            case ($urandom_range(0, 4))
                0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
                1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                2:       cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                3:       cp = 16'($urandom_range(16'hDC00, 16'hDFFF));
                default: cp = 16'($urandom_range(0, 16'hFFFF));
            endcase
            push_escape_u();
            push_hex4(cp);
        end
        else if (r < 90)
        begin
            push_escape_u();
            push_hex4(16'($urandom_range(16'hD800, 16'hDBFF)));
            push_escape_u();
            if ($urandom_range(0, 4) == 0)
            begin
                push_hex4(16'($urandom_range(0, 16'hFFFF)));
            end
            else
            begin
                push_hex4(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
        end
        else
        begin
            // lone high surrogate, then a random byte, sometimes after a backslash
            push_escape_u();
            push_hex4(16'($urandom_range(16'hD800, 16'hDBFF)));
            if ($urandom_range(0, 1) == 0)
            begin
                token_bytes.push_back(CHR_BSLASH);
            end
            token_bytes.push_back(8'($urandom_range(0, 255)));
        end
        last = token_bytes.size() - 1;
        for (int k = 0; k <= last; k++)
        begin
            fin = ((k == last) && ($urandom_range(0, 7) == 0)) || ($urandom_range(0, 99) == 0);
            send_item(token_bytes[k], fin);
        end
    endtask

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (!steady && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        int random_start;
        int tokens;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_text("\\n\\t\\r\\b\\f\\\\\\\"\\/\\q", 1'b0);
        send_text("\\u0000", 1'b1);
        send_text("\\uD83D\\uDE00", 1'b0);
        send_text("\\uDBFFx", 1'b1);
        send_text("\\u1", 1'b1);
        settle();

        random_start = items_sent;
        tokens = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            steady = ((items_sent - random_start) % 90) >= 65;
            send_token();
            tokens++;
            if (tokens == 40)
            begin
                settle();
            end
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: json_string_unescape_utf8.f
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/jsu_out.sv
rtl/json_string_unescape_utf8.sv
tb/json_string_unescape_utf8_checker.sv
tb/json_string_unescape_utf8_tb.sv
